FILE: rtl/core/hebt_pkg.sv
// package: shared constants, command and status types for the back-transform block
package hebt_pkg;

  localparam int MaxOrder = 8;
  localparam int FracBits = 16;
  localparam int IdxW = 3;
  localparam int AddrW = 6;
  localparam int DataW = 32;
  localparam int AccW = 64;

  localparam logic [1:0] OP_LOAD_H = 2'd0;
  localparam logic [1:0] OP_LOAD_P = 2'd1;
  localparam logic [1:0] OP_LOAD_Z = 2'd2;
  localparam logic [1:0] OP_START = 2'd3;

  // datapath micro-operations
  localparam logic [3:0] CMD_NOP = 4'd0;
  localparam logic [3:0] CMD_SCALE = 4'd1;
  localparam logic [3:0] CMD_CLR = 4'd2;
  localparam logic [3:0] CMD_MAC = 4'd3;
  localparam logic [3:0] CMD_DIV1 = 4'd4;
  localparam logic [3:0] CMD_DIV2 = 4'd5;
  localparam logic [3:0] CMD_UPD = 4'd6;
  localparam logic [3:0] CMD_EMIT = 4'd7;
  localparam logic [3:0] CMD_RDH = 4'd8;

  typedef struct packed {
    logic [3:0] op;
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
    logic [IdxW-1:0] k;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic h_zero;
    logic out_full;
  } dp_sts_t;

  function automatic logic signed [AccW-1:0] fmul(input logic signed [DataW-1:0] a,
                                                  input logic signed [DataW-1:0] b);
    logic signed [AccW-1:0] p;
    p = AccW'(a) * AccW'(b);
    return p >>> FracBits;
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [AccW-1:0] x);
    if (x > AccW'(64'sh7fffffff)) return 32'sh7fffffff;
    if (x < -AccW'(64'sh80000000)) return 32'sh80000000;
    return x[DataW-1:0];
  endfunction

endpackage

FILE: rtl/core/hebt_div.sv
// radix-2 restoring divider: sat32((n << FracBits) / d), truncated toward zero
module hebt_div import hebt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic signed [DataW-1:0] num,
  input  logic signed [DataW-1:0] den,
  output logic busy,
  output logic done,
  output logic signed [DataW-1:0] quo
);
  localparam int NW = DataW + FracBits;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DataW:0] rem_r, rem_nxt;
  logic [DataW-1:0] d_r, d_nxt;
  logic neg_r, neg_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic zero_r, zero_nxt;
  logic [DataW:0] sh;
  logic [NW:0] mag;
  logic signed [NW+1:0] sres;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    zero_nxt = zero_r;
    sh = {rem_r[DataW-1:0], q_r[NW-1]};
    if (start) begin
      q_nxt = {(num[DataW-1] ? DataW'(-num) : DataW'(num)), {FracBits{1'b0}}};
      d_nxt = den[DataW-1] ? DataW'(-den) : DataW'(den);
      neg_nxt = num[DataW-1] ^ den[DataW-1];
      zero_nxt = (den == '0);
      rem_nxt = '0;
      cnt_nxt = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, d_r}) begin
        rem_nxt = sh - {1'b0, d_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
    neg_r <= neg_nxt;
    zero_r <= zero_nxt;
  end

  assign mag = {1'b0, q_r};
  assign sres = neg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  assign busy = busy_r;
  assign done = done_r;
  assign quo = zero_r ? '0 : sat32(AccW'(sres));
endmodule

FILE: rtl/core/hebt_datapath.sv
// datapath: matrix stores, complex multiply-accumulate, divider and output register
module hebt_datapath import hebt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic ld_en,
  input  logic [1:0] ld_op,
  input  logic [IdxW-1:0] ld_row,
  input  logic [IdxW-1:0] ld_col,
  input  logic signed [DataW-1:0] ld_re,
  input  logic signed [DataW-1:0] ld_im,
  input  dp_cmd_t cmd,
  output dp_sts_t sts,
  output logic out_valid,
  input  logic out_ready,
  output logic [IdxW-1:0] o_row,
  output logic [IdxW-1:0] o_col,
  output logic signed [DataW-1:0] o_re,
  output logic signed [DataW-1:0] o_im,
  output logic o_last
);
  logic signed [DataW-1:0] h_re [MaxOrder*MaxOrder];
  logic signed [DataW-1:0] h_im [MaxOrder*MaxOrder];
  logic signed [DataW-1:0] z_re [MaxOrder*MaxOrder];
  logic signed [DataW-1:0] z_im [MaxOrder*MaxOrder];
  logic signed [DataW-1:0] p_re [MaxOrder];
  logic signed [DataW-1:0] p_im [MaxOrder];

  logic signed [DataW-1:0] ar_r, ai_r, zr_r, zi_r, pr_r, pi_r, hd_r;
  logic [AddrW-1:0] ha, za;
  logic signed [AccW-1:0] accr_r, acci_r;
  logic signed [DataW-1:0] sr_r, si_r;
  logic [3:0] op_d_r;
  dp_cmd_t cmd_d_r;
  logic signed [AccW-1:0] m0_r, m1_r, m2_r, m3_r;
  logic [3:0] op_m_r;
  dp_cmd_t cmd_m_r;
  logic signed [DataW-1:0] zr_m_r, zi_m_r;
  logic dv_start, dv_busy, dv_done;
  logic signed [DataW-1:0] dv_num, dv_den, dv_q;
  logic [1:0] dv_ph_r;
  logic ov_r;
  logic [IdxW-1:0] orow_r, ocol_r;
  logic signed [DataW-1:0] ore_r, oim_r;
  logic olast_r;

  assign ha = {cmd.i, cmd.k};
  assign za = (cmd.op == CMD_EMIT) ? {cmd.i, cmd.j} : {cmd.k, cmd.j};

  // memory write port: loads, then scale or update results
  always_ff @(posedge clk) begin
    if (ld_en) begin
      case (ld_op)
        OP_LOAD_H: begin
          h_re[{ld_row, ld_col}] <= ld_re;
          h_im[{ld_row, ld_col}] <= ld_im;
        end
        OP_LOAD_P: begin
          p_re[ld_row] <= ld_re;
          p_im[ld_row] <= ld_im;
        end
        OP_LOAD_Z: begin
          z_re[{ld_row, ld_col}] <= ld_re;
          z_im[{ld_row, ld_col}] <= '0;
        end
        default: ;
      endcase
    end else if (op_m_r == CMD_SCALE) begin
      z_re[{cmd_m_r.k, cmd_m_r.j}] <= sat32(m0_r);
      z_im[{cmd_m_r.k, cmd_m_r.j}] <= sat32(-m1_r);
    end else if (op_m_r == CMD_UPD) begin
      z_re[{cmd_m_r.k, cmd_m_r.j}] <= sat32(AccW'(zr_m_r) - (m0_r + m1_r));
      z_im[{cmd_m_r.k, cmd_m_r.j}] <= sat32(AccW'(zi_m_r) - (m2_r - m3_r));
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    ar_r <= h_re[ha];
    ai_r <= h_im[ha];
    hd_r <= h_im[{cmd.i, cmd.i}];
    zr_r <= z_re[za];
    zi_r <= z_im[za];
    pr_r <= p_re[cmd.k];
    pi_r <= p_im[cmd.k];
    cmd_d_r <= cmd;
  end

  // multiply stage
  always_ff @(posedge clk) begin
    case (cmd_d_r.op)
      CMD_SCALE: begin
        m0_r <= fmul(zr_r, pr_r);
        m1_r <= fmul(zr_r, pi_r);
        m2_r <= '0;
        m3_r <= '0;
      end
      CMD_UPD: begin
        m0_r <= fmul(sr_r, ar_r);
        m1_r <= fmul(si_r, ai_r);
        m2_r <= fmul(si_r, ar_r);
        m3_r <= fmul(sr_r, ai_r);
      end
      default: begin
        m0_r <= fmul(ar_r, zr_r);
        m1_r <= fmul(ai_r, zi_r);
        m2_r <= fmul(ar_r, zi_r);
        m3_r <= fmul(ai_r, zr_r);
      end
    endcase
    zr_m_r <= zr_r;
    zi_m_r <= zi_r;
    cmd_m_r <= cmd_d_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_d_r <= CMD_NOP;
      op_m_r <= CMD_NOP;
    end else begin
      op_d_r <= cmd.op;
      op_m_r <= cmd_d_r.op;
    end
  end

  // accumulate
  always_ff @(posedge clk) begin
    if (cmd.op == CMD_CLR) begin
      accr_r <= '0;
      acci_r <= '0;
    end else if (op_m_r == CMD_MAC) begin
      accr_r <= accr_r + (m0_r - m1_r);
      acci_r <= acci_r + (m2_r + m3_r);
    end
  end

  // divider sequencing: re/1st, im/1st, re/2nd, im/2nd
  assign dv_den = hd_r;
  assign dv_num = (dv_ph_r == 2'd0) ? (op_d_r == CMD_DIV1 ? sat32(accr_r) : sr_r) :
                  (op_d_r == CMD_DIV1 ? sat32(acci_r) : si_r);
  assign dv_start = (op_d_r == CMD_DIV1 || op_d_r == CMD_DIV2) && !dv_busy && !dv_done
                    && dv_ph_r != 2'd2;

  // phase restarts whenever the division command changes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ph_r <= 2'd0;
    end else if (!(op_d_r == CMD_DIV1 || op_d_r == CMD_DIV2) || cmd.op != op_d_r) begin
      dv_ph_r <= 2'd0;
    end else if (dv_done) begin
      if (dv_ph_r == 2'd0) sr_r <= dv_q;
      else si_r <= dv_q;
      dv_ph_r <= dv_ph_r + 2'd1;
    end
  end

  hebt_div u_div (
    .clk(clk), .rst_n(rst_n), .start(dv_start), .num(dv_num), .den(dv_den),
    .busy(dv_busy), .done(dv_done), .quo(dv_q)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (op_d_r == CMD_EMIT) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
    if (op_d_r == CMD_EMIT) begin
      orow_r <= cmd_d_r.i;
      ocol_r <= cmd_d_r.j;
      ore_r <= zr_r;
      oim_r <= zi_r;
      olast_r <= cmd_d_r.last;
    end
  end

  assign sts.busy = dv_busy || dv_start || (dv_ph_r != 2'd2 &&
                    (op_d_r == CMD_DIV1 || op_d_r == CMD_DIV2));
  assign sts.h_zero = (hd_r == '0);
  assign sts.out_full = ov_r;
  assign out_valid = ov_r;
  assign o_row = orow_r;
  assign o_col = ocol_r;
  assign o_re = ore_r;
  assign o_im = oim_r;
  assign o_last = olast_r;
endmodule

FILE: rtl/core/hebt_ctrl.sv
// controller: sequences scale, dot product, division, update and emit passes
module hebt_ctrl import hebt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic [3:0] order,
  input  dp_sts_t sts,
  input  logic out_ready,
  output logic idle,
  output dp_cmd_t cmd
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCALE = 4'd1;
  localparam logic [3:0] S_ROW = 4'd2;
  localparam logic [3:0] S_HWAIT = 4'd3;
  localparam logic [3:0] S_HCHK = 4'd4;
  localparam logic [3:0] S_MAC = 4'd5;
  localparam logic [3:0] S_MWAIT = 4'd6;
  localparam logic [3:0] S_DIV1 = 4'd7;
  localparam logic [3:0] S_DIV2 = 4'd8;
  localparam logic [3:0] S_UPD = 4'd9;
  localparam logic [3:0] S_UWAIT = 4'd10;
  localparam logic [3:0] S_EMIT = 4'd11;
  localparam logic [3:0] S_EWAIT = 4'd12;

  logic [3:0] st_r, st_nxt;
  logic [IdxW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic [IdxW-1:0] nm1_r, nm1_nxt;
  logic [1:0] w_r, w_nxt;
  logic [IdxW-1:0] nm1;

  assign nm1 = (order > 4'(MaxOrder)) ? IdxW'(MaxOrder - 1) : IdxW'(order - 4'd1);

  always_comb begin
    st_nxt = st_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    nm1_nxt = nm1_r;
    w_nxt = w_r;
    cmd = '0;
    cmd.op = CMD_NOP;
    cmd.i = i_r;
    cmd.j = j_r;
    cmd.k = k_r;
    case (st_r)
      S_IDLE: begin
        if (start && order != 4'd0) begin
          nm1_nxt = nm1;
          st_nxt = S_SCALE;
          i_nxt = '0;
          j_nxt = '0;
          k_nxt = '0;
        end
      end
      S_SCALE: begin
        cmd.op = CMD_SCALE;
        if (j_r == nm1_r) begin
          j_nxt = '0;
          if (k_r == nm1_r) begin
            st_nxt = S_ROW;
            i_nxt = IdxW'(1);
            w_nxt = 2'd3;
          end else k_nxt = k_r + 1'b1;
        end else j_nxt = j_r + 1'b1;
      end
      S_ROW: begin
        // drain writes, then read diagonal
        cmd.op = CMD_RDH;
        if (w_r != 2'd0) w_nxt = w_r - 1'b1;
        else if (nm1_r == '0 || i_r == '0) begin
          st_nxt = S_EMIT;
          i_nxt = '0;
          j_nxt = '0;
        end else st_nxt = S_HWAIT;
      end
      S_HWAIT: begin
        cmd.op = CMD_RDH;
        st_nxt = S_HCHK;
      end
      S_HCHK: begin
        if (sts.h_zero) begin
          w_nxt = 2'd0;
          if (i_r == nm1_r) begin
            st_nxt = S_EMIT;
            i_nxt = '0;
            j_nxt = '0;
          end else begin
            i_nxt = i_r + 1'b1;
            st_nxt = S_ROW;
          end
        end else begin
          j_nxt = '0;
          k_nxt = '0;
          cmd.op = CMD_CLR;
          st_nxt = S_MAC;
        end
      end
      S_MAC: begin
        cmd.op = CMD_MAC;
        if (k_r == i_r - 1'b1) begin
          st_nxt = S_MWAIT;
          w_nxt = 2'd3;
        end else k_nxt = k_r + 1'b1;
      end
      S_MWAIT: begin
        cmd.op = CMD_RDH;
        if (w_r != 2'd0) w_nxt = w_r - 1'b1;
        else st_nxt = S_DIV1;
      end
      S_DIV1: begin
        cmd.op = CMD_DIV1;
        w_nxt = 2'd2;
        if (w_r == 2'd2 && !sts.busy) begin
          st_nxt = S_DIV2;
          w_nxt = 2'd0;
        end
      end
      S_DIV2: begin
        cmd.op = CMD_DIV2;
        w_nxt = 2'd2;
        if (w_r == 2'd2 && !sts.busy) begin
          st_nxt = S_UPD;
          k_nxt = '0;
        end
      end
      S_UPD: begin
        cmd.op = CMD_UPD;
        if (k_r == i_r - 1'b1) begin
          st_nxt = S_UWAIT;
          w_nxt = 2'd3;
        end else k_nxt = k_r + 1'b1;
      end
      S_UWAIT: begin
        cmd.op = CMD_RDH;
        if (w_r != 2'd0) w_nxt = w_r - 1'b1;
        else if (j_r == nm1_r) begin
          if (i_r == nm1_r) begin
            st_nxt = S_EMIT;
            i_nxt = '0;
            j_nxt = '0;
          end else begin
            i_nxt = i_r + 1'b1;
            st_nxt = S_ROW;
          end
        end else begin
          j_nxt = j_r + 1'b1;
          k_nxt = '0;
          cmd.op = CMD_CLR;
          st_nxt = S_MAC;
        end
      end
      S_EMIT: begin
        if (!sts.out_full || out_ready) begin
          cmd.op = CMD_EMIT;
          cmd.last = (i_r == nm1_r) && (j_r == nm1_r);
          st_nxt = S_EWAIT;
        end
      end
      S_EWAIT: begin
        if (i_r == nm1_r && j_r == nm1_r) st_nxt = S_IDLE;
        else begin
          st_nxt = S_EMIT;
          if (j_r == nm1_r) begin
            j_nxt = '0;
            i_nxt = i_r + 1'b1;
          end else j_nxt = j_r + 1'b1;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
      nm1_r <= '0;
      w_r <= '0;
    end else begin
      st_r <= st_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
      nm1_r <= nm1_nxt;
      w_r <= w_nxt;
    end
  end

  assign idle = (st_r == S_IDLE);
endmodule

FILE: rtl/core/hermitian_eigvec_back_transform.sv
// top level: hermitian eigenvector back-transform, stream in, stream out
// Load items (operation 0..2) write the Householder matrix, the phase
// vector or the real part of the eigenvector matrix.
// A start item (operation 3) scales every entry by the conjugate phase,
// then for every row with a nonzero diagonal imaginary part forms a complex
// dot product per column, divides it twice by that value on a shared
// serial divider (four quotients per column) and subtracts the correction
// down the column. The divider dominates the run time. The n*n results
// leave row by row on the out_ stream, last one flagged on out_tlast; the
// entries are sent one at a time through a single output register.
// in_tready is low from a start until the final result has been taken.
// A stalled receiver holds the output register and pauses the emit pass.
// Reset (rst_n low, synchronous) sets the order register to 8 and idles
// the sequencer; the matrix stores are undefined until loaded.
module hermitian_eigvec_back_transform import hebt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_wr_en,
  input  logic [3:0] cfg_wr_data,
  input  logic in_tvalid,
  output logic in_tready,
  // operation[1:0], row[4:2], col[7:5], value_re[39:8], value_im[71:40]
  input  logic [71:0] in_tdata,
  output logic out_tvalid,
  input  logic out_tready,
  // out_row[2:0], out_col[5:3], out_re[37:6], out_im[69:38]
  output logic [71:0] out_tdata,
  // last_result
  output logic out_tlast
);
  logic [3:0] order_r;
  logic idle, acc, run_start;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [IdxW-1:0] o_row, o_col;
  logic signed [DataW-1:0] o_re, o_im;
  logic [1:0] op;

  always_ff @(posedge clk) begin
    if (!rst_n) order_r <= 4'd8;
    else if (cfg_wr_en) order_r <= cfg_wr_data;
  end

  assign op = in_tdata[1:0];
  assign in_tready = idle && !out_tvalid;
  assign acc = in_tvalid && in_tready;
  assign run_start = acc && op == OP_START;

  hebt_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(run_start), .order(order_r), .sts(sts),
    .out_ready(out_tready), .idle(idle), .cmd(cmd)
  );

  hebt_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ld_en(acc && op != OP_START), .ld_op(op),
    .ld_row(in_tdata[4:2]), .ld_col(in_tdata[7:5]),
    .ld_re(in_tdata[39:8]), .ld_im(in_tdata[71:40]),
    .cmd(cmd), .sts(sts), .out_valid(out_tvalid), .out_ready(out_tready),
    .o_row(o_row), .o_col(o_col), .o_re(o_re), .o_im(o_im), .o_last(out_tlast)
  );

  assign out_tdata = {2'b00, o_im, o_re, o_col, o_row};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !idle |-> !in_tready) else $error("input accepted while running");
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> idle)
    else $error("sequencer not idle after last result");
endmodule

FILE: test/tb_hermitian_eigvec_back_transform.sv
// testbench: random and directed stream checks of the eigenvector back-transform
`timescale 1ns / 100ps

module tb_hermitian_eigvec_back_transform import hebt_pkg::*;;

  typedef struct {
    logic [2:0] row;
    logic [2:0] col;
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic last;
  } entry_t;

  class eigvec_scoreboard;
    int order;
    int errors;
    logic signed [31:0] h_re[64], h_im[64], ph_re[8], ph_im[8], z_re[64], z_im[64];
    entry_t entries_due[$];

    function new();
      order = 8;
      errors = 0;
    endfunction

    function longint prod(logic signed [31:0] a, logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> FracBits;
    endfunction

    function logic signed [31:0] clip(longint x);
      if (x > 64'sh7fffffff) return 32'sh7fffffff;
      if (x < -64'sh80000000) return 32'sh80000000;
      return x[31:0];
    endfunction

    function logic signed [31:0] quot(logic signed [31:0] a, logic signed [31:0] d);
      longint num;
      num = longint'(a) <<< FracBits;
      if (d == 0) return 0;
      return clip(num / longint'(d));
    endfunction

    function void set_order(logic [3:0] v);
      order = (v > MaxOrder) ? MaxOrder : v;
    endfunction

    function void note_input(logic [1:0] op, logic [2:0] r, logic [2:0] c,
                             logic signed [31:0] vre, logic signed [31:0] vim);
      int i, j, k, p;
      longint ar_acc, ai_acc, tr, ti;
      logic signed [31:0] z, hd, sr, si;
      entry_t e;
      case (op)
        OP_LOAD_H: begin
          h_re[r * 8 + c] = vre;
          h_im[r * 8 + c] = vim;
        end
        OP_LOAD_P: begin
          ph_re[r] = vre;
          ph_im[r] = vim;
        end
        OP_LOAD_Z: begin
          z_re[r * 8 + c] = vre;
          z_im[r * 8 + c] = 0;
        end
        default: begin
          if (order == 0) return;
          for (k = 0; k < order; k++)
            for (j = 0; j < order; j++) begin
              z = z_re[k * 8 + j];
              z_re[k * 8 + j] = clip(prod(z, ph_re[k]));
              z_im[k * 8 + j] = clip(-prod(z, ph_im[k]));
            end
          for (i = 1; i < order; i++) begin
            hd = h_im[i * 8 + i];
            if (hd == 0) continue;
            for (j = 0; j < order; j++) begin
              ar_acc = 0;
              ai_acc = 0;
              for (k = 0; k < i; k++) begin
                ar_acc += prod(h_re[i * 8 + k], z_re[k * 8 + j])
                        - prod(h_im[i * 8 + k], z_im[k * 8 + j]);
                ai_acc += prod(h_re[i * 8 + k], z_im[k * 8 + j])
                        + prod(h_im[i * 8 + k], z_re[k * 8 + j]);
              end
              sr = quot(quot(clip(ar_acc), hd), hd);
              si = quot(quot(clip(ai_acc), hd), hd);
              for (k = 0; k < i; k++) begin
                p = k * 8 + j;
                tr = prod(sr, h_re[i * 8 + k]) + prod(si, h_im[i * 8 + k]);
                ti = prod(si, h_re[i * 8 + k]) - prod(sr, h_im[i * 8 + k]);
                z_re[p] = clip(longint'(z_re[p]) - tr);
                z_im[p] = clip(longint'(z_im[p]) - ti);
              end
            end
          end
          for (i = 0; i < order; i++)
            for (j = 0; j < order; j++) begin
              e.row = 3'(i);
              e.col = 3'(j);
              e.re = z_re[i * 8 + j];
              e.im = z_im[i * 8 + j];
              e.last = (i == order - 1) && (j == order - 1);
              entries_due.push_back(e);
            end
        end
      endcase
    endfunction

    function void check_result(logic [71:0] d, logic last);
      entry_t e;
      if (entries_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: data %h last %b", d, last);
        return;
      end
      e = entries_due.pop_front();
      if (d[2:0] !== e.row || d[5:3] !== e.col || d[37:6] !== e.re ||
          d[69:38] !== e.im || last !== e.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp r%0d c%0d %h %h l%b, got r%0d c%0d %h %h l%b",
                   e.row, e.col, e.re, e.im, e.last,
                   d[2:0], d[5:3], d[37:6], d[69:38], last);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [3:0] cfg_wr_data;
  logic in_tvalid;
  logic in_tready;
  logic [71:0] in_tdata;
  logic out_tvalid;
  logic out_tready = 1'b1;
  logic [71:0] out_tdata;
  logic out_tlast;

  eigvec_scoreboard sb;
  int burst_left;
  int idle_cycles = 0;
  int stall_mode = 0;
  int cyc = 0;
  int items_sent;

  hermitian_eigvec_back_transform u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // receiver stall pattern and result check
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tlast);
    if (cyc % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= ($urandom_range(0, 7) == 0);
      default: out_tready <= ((cyc / 5) % 3) != 0;
    endcase
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 200000) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      default: return $signed($urandom_range(0, 1 << 18)) - (1 << 17);
    endcase
  endfunction

  task automatic send(logic [1:0] op, logic [2:0] r, logic [2:0] c,
                      logic signed [31:0] vre, logic signed [31:0] vim);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= {vim, vre, c, r, op};
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, r, c, vre, vim);
    items_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (sb.entries_due.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_order(logic [3:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_order(v);
  endtask

  task automatic fill_all();
    for (int r = 0; r < 8; r++) begin
      send(OP_LOAD_P, 3'(r), 3'($urandom), rand_value(), rand_value());
      for (int c = 0; c < 8; c++) begin
        send(OP_LOAD_H, 3'(r), 3'(c), rand_value(),
             (r == c && r == 3) ? 32'sh0 : rand_value());
        send(OP_LOAD_Z, 3'(r), 3'(c), rand_value(), rand_value());
      end
    end
  endtask

  initial begin
    logic [1:0] op;
    sb = new();
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 4'h0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    burst_left = 0;
    items_sent = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every store entry written before any start, order 8 from reset
    fill_all();
    send(OP_START, 0, 0, 0, 0);
    send(OP_START, 7, 7, 32'sh7fffffff, 32'sh80000000);

    // extreme values and a zero diagonal on row 1
    drain();
    send(OP_LOAD_H, 1, 0, 32'sh7fffffff, 32'sh80000000);
    send(OP_LOAD_H, 1, 1, 32'sh00010000, 32'sh00000000);
    send(OP_LOAD_H, 2, 2, 32'sh00000000, 32'sh00000001);
    send(OP_LOAD_P, 0, 0, 32'sh80000000, 32'sh7fffffff);
    send(OP_LOAD_Z, 0, 0, 32'sh80000000, 32'shffffffff);
    send(OP_LOAD_Z, 7, 7, 32'sh7fffffff, 32'sh0);
    set_order(4'd3);
    send(OP_START, 0, 0, 0, 0);
    set_order(4'd0);
    send(OP_START, 0, 0, 0, 0);
    set_order(4'd15);
    send(OP_START, 0, 0, 0, 0);
    set_order(4'd1);
    send(OP_START, 0, 0, 0, 0);

    while (items_sent < 350) begin
      case ($urandom_range(0, 5))
        0: set_order(4'd1);
        1: set_order(4'd8);
        2: set_order(4'($urandom_range(9, 15)));
        3: set_order(4'd0);
        default: set_order(4'($urandom_range(2, 7)));
      endcase
      repeat ($urandom_range(4, 24)) begin
        op = 2'($urandom_range(0, 2));
        send(op, 3'($urandom), 3'($urandom), rand_value(),
             ($urandom_range(0, 5) == 0) ? 32'sh0 : rand_value());
      end
      send(OP_START, 3'($urandom), 3'($urandom), $urandom, $urandom);
      if ($urandom_range(0, 3) == 0) send(OP_START, 0, 0, 0, 0);
    end

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
